>>> rtl/core/periodic_five_point_laplacian_defines.svh
// Assertion helpers for the periodic Laplacian block.
`ifndef PERIODIC_FIVE_POINT_LAPLACIAN_DEFINES_SVH
`define PERIODIC_FIVE_POINT_LAPLACIAN_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, off while reset is low.
`define LPL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, off while reset is low.
`define LPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define LPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/lpl_pkg.sv
package lpl_pkg;

    typedef enum logic [0:0] {
        ST_STREAM,
        ST_TAIL
    } lpl_state_t;

    // Stage load strobes for the arithmetic lanes.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } lpl_adv_t;

    localparam int          CFG_INDEX_W           = 1;
    localparam logic [0:0]  REG_SCALE_COEFFICIENT = 1'b0;
    localparam logic [0:0]  REG_SCALE_SHIFT       = 1'b1;

    localparam logic [31:0] COEF_RESET = 32'd1;
    localparam logic [5:0]  SHIFT_RESET = 6'd0;

    localparam logic [31:0] LAP_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] LAP_MIN = 32'h8000_0000;

    // Wrapped results in a long period: four window positions, then the duplicate.
    localparam logic [2:0]  BIG_TAIL_STEPS = 3'd4;
    localparam logic [2:0]  DUP_OFFSET     = 3'd2;

    // Short period (length 1 to 4): window cell holding tap t of wrapped point j.
    // Window cell i holds point p-1-i.
    function automatic logic [1:0] small_tap(input logic [2:0] p, input logic [2:0] j,
                                             input logic [2:0] t);
        logic [4:0] v;
        logic [4:0] pe;
        int         i;
        pe = {2'b00, p};
        v  = {2'b00, j} + {2'b00, t} + (pe << 1) - 5'd2;
        for (i = 0; i < 4; i++)
        begin
            if (v >= pe)
            begin
                v = v - pe;
            end
        end
        return 2'(p[1:0] - 2'd1 - v[1:0]);
    endfunction

endpackage

>>> rtl/core/lpl_cell.sv
module lpl_cell #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic signed [SAMPLE_WIDTH-1:0] d_real,
    input  logic signed [SAMPLE_WIDTH-1:0] d_imag,
    output logic signed [SAMPLE_WIDTH-1:0] q_real,
    output logic signed [SAMPLE_WIDTH-1:0] q_imag
);

    logic signed [SAMPLE_WIDTH-1:0] real_reg;
    logic signed [SAMPLE_WIDTH-1:0] imag_reg;

    // Take the neighbour's sample on each shift.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            real_reg <= d_real;
            imag_reg <= d_imag;
        end
    end

    assign q_real = real_reg;
    assign q_imag = imag_reg;

endmodule

>>> rtl/core/lpl_lane.sv
module lpl_lane import lpl_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  lpl_adv_t                       adv,
    input  logic signed [SAMPLE_WIDTH-1:0] taps [5],
    input  logic        [31:0]             coef,
    input  logic        [5:0]              shift,
    output logic        [31:0]             lap,
    output logic                           sat
);

    localparam int SUMW = SAMPLE_WIDTH + 6;
    localparam int PW   = SUMW + 33;

    logic signed [SUMW-1:0] t_ext [5];
    logic signed [SUMW-1:0] sum_next;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [32:0]     coef_s;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   shifted;
    logic        [PW-32:0]  upper;
    logic                   fits;
    logic        [31:0]     lap_next;
    logic        [31:0]     lap_reg;
    logic                   sat_next;
    logic                   sat_reg;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            t_ext[i] = SUMW'(taps[i]);
        end
    end

    // Stencil -1, 16, -30, 16, -1 with shifts only.
    assign sum_next = (t_ext[1] <<< 4) + (t_ext[3] <<< 4) - (t_ext[2] <<< 5)
                    + (t_ext[2] <<< 1) - t_ext[0] - t_ext[4];

    assign coef_s    = $signed({1'b0, coef});
    assign prod_next = sum_reg * coef_s;

    // Arithmetic shift floors; clip to signed 32 bits.
    assign shifted  = prod_reg >>> shift;
    assign upper    = shifted[PW-1:31];
    assign fits     = (&upper) | ~(|upper);
    assign lap_next = fits ? shifted[31:0] : (shifted[PW-1] ? LAP_MIN : LAP_MAX);
    assign sat_next = ~fits;

    always_ff @(posedge clk)
    begin
        if (adv.load1)
        begin
            sum_reg <= sum_next;
        end
        if (adv.load2)
        begin
            prod_reg <= prod_next;
        end
        if (adv.load3)
        begin
            lap_reg <= lap_next;
            sat_reg <= sat_next;
        end
    end

    assign lap = lap_reg;
    assign sat = sat_reg;

endmodule

>>> rtl/core/periodic_five_point_laplacian.sv
// Periodic fourth-order Laplacian of a complex grid, streamed one point per request.
// Input channel (in_valid/in_ready): one distinct grid point per request, real and
// imaginary parts side by side; last_point closes the period (a point at index
// MAX_POINTS-1 closes it regardless). Output channel (out_valid/out_ready): one
// Laplacian value per request with its grid index, a saturation flag and last_result.
// Throughput: one point per cycle while the period streams and the first stage can
// advance; from point 4 on, each point yields the result two places back. After the
// last point the input is held off while the wrapped results go out, one per cycle
// while the first stage can advance: indices P-2, P-1, 0, 1, then the duplicate end
// point P, for a period of 5 or more points; P+1 results for a shorter one.
// Each issued request passes through the three-stage arithmetic lanes (tap sum,
// multiply, shift and clip) before it reaches out_valid.
// Configuration: cfg_write with cfg_index 0 writes the coefficient, 1 the shift;
// write only while idle.
// Reset: period counter to zero, pipeline empty, coefficient 1, shift 0.
// Receiver stall: results hold in the output register; bubbles upstream close up,
// and the input drops ready once the first stage cannot advance.
`include "periodic_five_point_laplacian_defines.svh"
module periodic_five_point_laplacian import lpl_pkg::*; #(
    parameter int MAX_POINTS   = 4096,
    parameter int SAMPLE_WIDTH = 24,
    localparam int IW = $clog2(MAX_POINTS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] point_real,
    input  logic signed [SAMPLE_WIDTH-1:0] point_imag,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [IW-1:0]                  point_index,
    output logic signed [31:0]             lap_real,
    output logic signed [31:0]             lap_imag,
    output logic                           saturated,
    output logic                           last_result
);

    localparam int KW = $clog2(MAX_POINTS);
    localparam int SW = SAMPLE_WIDTH;

    // Configuration registers.
    logic [31:0] coef_reg;
    logic [5:0]  shift_reg;

    // Sequencer.
    lpl_state_t  state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [IW-1:0] p_reg, p_next;
    logic [2:0]    step_reg, step_next;
    logic          big_reg, big_next;
    logic [2:0]    n_tail;
    logic          accept;
    logic          is_last;
    logic          issue;
    logic [IW-1:0] req_idx;
    logic          req_last;

    // Pipeline control.
    logic     v1_reg, v2_reg, v3_reg;
    logic     s1_ready, s2_ready, s3_ready;
    lpl_adv_t adv;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic          last1_reg, last2_reg, last3_reg;

    // Sample cells: window holds the four latest points, head the first four.
    logic signed [SW-1:0] win_re [4];
    logic signed [SW-1:0] win_im [4];
    logic signed [SW-1:0] win_d_re [4];
    logic signed [SW-1:0] win_d_im [4];
    logic signed [SW-1:0] head_re [4];
    logic signed [SW-1:0] head_im [4];
    logic signed [SW-1:0] head_d_re [4];
    logic signed [SW-1:0] head_d_im [4];
    logic                 win_shift;
    logic                 head_shift;

    // Tap selection.
    logic signed [SW-1:0] seq_re [8];
    logic signed [SW-1:0] seq_im [8];
    logic signed [SW-1:0] tap_re [5];
    logic signed [SW-1:0] tap_im [5];
    logic [2:0]           off;
    logic [2:0]           j_small;
    logic [1:0]           cell_sel;

    logic                 sat_re, sat_im;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= COEF_RESET;
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCALE_COEFFICIENT: coef_reg  <= cfg_data;
                REG_SCALE_SHIFT:       shift_reg <= cfg_data[5:0];
            endcase
        end
    end

    // ---------------------------------------------------------------- cells
    // Shift a new point into both chains; head only fills over the first four.
    assign win_shift  = accept;
    assign head_shift = accept && (k_reg < KW'(4));

    always_comb
    begin
        win_d_re[0]  = point_real;
        win_d_im[0]  = point_imag;
        head_d_re[0] = point_real;
        head_d_im[0] = point_imag;
        for (int i = 1; i < 4; i++)
        begin
            win_d_re[i]  = win_re[i-1];
            win_d_im[i]  = win_im[i-1];
            head_d_re[i] = head_re[i-1];
            head_d_im[i] = head_im[i-1];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_cells
        lpl_cell #(.SAMPLE_WIDTH(SW)) u_win (
            .clk      (clk),
            .shift_en (win_shift),
            .d_real   (win_d_re[g]),
            .d_imag   (win_d_im[g]),
            .q_real   (win_re[g]),
            .q_imag   (win_im[g])
        );
        lpl_cell #(.SAMPLE_WIDTH(SW)) u_head (
            .clk      (clk),
            .shift_en (head_shift),
            .d_real   (head_d_re[g]),
            .d_imag   (head_d_im[g]),
            .q_real   (head_re[g]),
            .q_imag   (head_im[g])
        );
    end

    // ---------------------------------------------------------------- pipeline
    // Each stage advances when the one after it is empty or advancing.
    assign s3_ready  = !v3_reg || out_ready;
    assign s2_ready  = !v2_reg || s3_ready;
    assign s1_ready  = !v1_reg || s2_ready;
    assign adv.load1 = issue;
    assign adv.load2 = v1_reg && s2_ready;
    assign adv.load3 = v2_reg && s3_ready;

    // ---------------------------------------------------------------- sequencer
    assign in_ready = (state_reg == ST_STREAM) && s1_ready;
    assign accept   = in_valid && in_ready;
    assign is_last  = last_point || (k_reg == KW'(MAX_POINTS - 1));
    assign n_tail   = big_reg ? BIG_TAIL_STEPS : p_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        step_next  = step_reg;
        big_next   = big_reg;
        issue      = 1'b0;
        req_idx    = IW'(k_reg) - IW'(2);
        req_last   = 1'b0;
        unique case (state_reg)
            ST_STREAM:
            begin
                // Steady result for the point two back, from point 4 on.
                issue = accept && (k_reg > KW'(3));
                if (accept)
                begin
                    if (is_last)
                    begin
                        k_next     = '0;
                        p_next     = IW'(k_reg) + IW'(1);
                        big_next   = k_reg > KW'(3);
                        step_next  = '0;
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            ST_TAIL:
            begin
                issue    = s1_ready;
                req_last = (step_reg == n_tail);
                if (req_last)
                begin
                    req_idx = p_reg;
                end
                else if (big_reg)
                begin
                    unique case (step_reg[1:0])
                        2'd0: req_idx = p_reg - IW'(2);
                        2'd1: req_idx = p_reg - IW'(1);
                        2'd2: req_idx = '0;
                        2'd3: req_idx = IW'(1);
                    endcase
                end
                else
                begin
                    req_idx = IW'(step_reg);
                end
                if (issue)
                begin
                    if (req_last)
                    begin
                        state_next = ST_STREAM;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STREAM;
            k_reg     <= '0;
            p_reg     <= '0;
            step_reg  <= '0;
            big_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            p_reg     <= p_next;
            step_reg  <= step_next;
            big_reg   <= big_next;
            if (s1_ready)
            begin
                v1_reg <= issue;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
            if (s3_ready)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Index and last mark ride alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (adv.load1)
        begin
            idx1_reg  <= req_idx;
            last1_reg <= req_last;
        end
        if (adv.load2)
        begin
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
        end
        if (adv.load3)
        begin
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
        end
    end

    // ---------------------------------------------------------------- taps
    // Long period: slide five taps along W3 W2 W1 W0 H3 H2 H1 H0.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            seq_re[i]     = win_re[3-i];
            seq_im[i]     = win_im[3-i];
            seq_re[4 + i] = head_re[3-i];
            seq_im[4 + i] = head_im[3-i];
        end
    end

    assign off     = (step_reg == n_tail) ? DUP_OFFSET : step_reg;
    assign j_small = (step_reg == n_tail) ? 3'd0 : step_reg;

    always_comb
    begin
        cell_sel = '0;
        for (int t = 0; t < 5; t++)
        begin
            tap_re[t] = '0;
            tap_im[t] = '0;
        end
        priority if (state_reg == ST_STREAM)
        begin
            for (int t = 0; t < 4; t++)
            begin
                tap_re[t] = win_re[3-t];
                tap_im[t] = win_im[3-t];
            end
            tap_re[4] = point_real;
            tap_im[4] = point_imag;
        end
        else if (big_reg)
        begin
            for (int t = 0; t < 5; t++)
            begin
                tap_re[t] = seq_re[3'(off + 3'(t))];
                tap_im[t] = seq_im[3'(off + 3'(t))];
            end
        end
        else
        begin
            // Short period: every tap comes out of the window by wrapped index.
            for (int t = 0; t < 5; t++)
            begin
                cell_sel  = small_tap(p_reg[2:0], j_small, 3'(t));
                tap_re[t] = win_re[cell_sel];
                tap_im[t] = win_im[cell_sel];
            end
        end
    end

    // ---------------------------------------------------------------- lanes
    lpl_lane #(.SAMPLE_WIDTH(SW)) u_lane_re (
        .clk   (clk),
        .adv   (adv),
        .taps  (tap_re),
        .coef  (coef_reg),
        .shift (shift_reg),
        .lap   (lap_real),
        .sat   (sat_re)
    );

    lpl_lane #(.SAMPLE_WIDTH(SW)) u_lane_im (
        .clk   (clk),
        .adv   (adv),
        .taps  (tap_im),
        .coef  (coef_reg),
        .shift (shift_reg),
        .lap   (lap_imag),
        .sat   (sat_im)
    );

    assign out_valid   = v3_reg;
    assign point_index = idx3_reg;
    assign saturated   = sat_re | sat_im;
    assign last_result = last3_reg;

    // ---------------------------------------------------------------- checks
    `LPL_ASSERT_NEXT(a_last_enters_tail, clk, rst_n, accept && is_last, state_reg == ST_TAIL, "last point did not start the wrap-up")
    `LPL_ASSERT_IMPLIES(a_step_bounded, clk, rst_n, state_reg == ST_TAIL, step_reg <= n_tail, "wrap-up step beyond its length")
    `LPL_ASSERT_NEXT(a_stage1_holds, clk, rst_n, v1_reg && !s2_ready, v1_reg && $stable(idx1_reg), "stalled request lost")
    `LPL_ASSERT_IMPLIES(a_dup_index, clk, rst_n, out_valid && last_result, point_index != '0, "end point carries index zero")

endmodule
